// ===== sv/sha512_pkg.sv =====
package sha512_pkg;

  // Block geometry
  localparam int WORDS_PER_BLOCK = 16;
  localparam int ROUNDS          = 80;
  localparam int DIGEST_WORDS    = 8;

  // One input transfer
  typedef struct packed {
    logic [63:0] msg_word;
    logic        final_block;
  } msg_t;

  // One result transfer
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        last;
  } digest_t;

  // Eight working variables a..h, a at index 0
  typedef logic [7:0][63:0] vars_t;

  // Message schedule taps used by one round
  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w9;
    logic [63:0] w14;
  } sched_taps_t;

  // Initial hash value H0..H7
  function automatic logic [63:0] init_hash(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  // Round constants K0..K79
  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] v;
    case (idx)
      7'd0:  v = 64'h428a2f98d728ae22;
      7'd1:  v = 64'h7137449123ef65cd;
      7'd2:  v = 64'hb5c0fbcfec4d3b2f;
      7'd3:  v = 64'he9b5dba58189dbbc;
      7'd4:  v = 64'h3956c25bf348b538;
      7'd5:  v = 64'h59f111f1b605d019;
      7'd6:  v = 64'h923f82a4af194f9b;
      7'd7:  v = 64'hab1c5ed5da6d8118;
      7'd8:  v = 64'hd807aa98a3030242;
      7'd9:  v = 64'h12835b0145706fbe;
      7'd10: v = 64'h243185be4ee4b28c;
      7'd11: v = 64'h550c7dc3d5ffb4e2;
      7'd12: v = 64'h72be5d74f27b896f;
      7'd13: v = 64'h80deb1fe3b1696b1;
      7'd14: v = 64'h9bdc06a725c71235;
      7'd15: v = 64'hc19bf174cf692694;
      7'd16: v = 64'he49b69c19ef14ad2;
      7'd17: v = 64'hefbe4786384f25e3;
      7'd18: v = 64'h0fc19dc68b8cd5b5;
      7'd19: v = 64'h240ca1cc77ac9c65;
      7'd20: v = 64'h2de92c6f592b0275;
      7'd21: v = 64'h4a7484aa6ea6e483;
      7'd22: v = 64'h5cb0a9dcbd41fbd4;
      7'd23: v = 64'h76f988da831153b5;
      7'd24: v = 64'h983e5152ee66dfab;
      7'd25: v = 64'ha831c66d2db43210;
      7'd26: v = 64'hb00327c898fb213f;
      7'd27: v = 64'hbf597fc7beef0ee4;
      7'd28: v = 64'hc6e00bf33da88fc2;
      7'd29: v = 64'hd5a79147930aa725;
      7'd30: v = 64'h06ca6351e003826f;
      7'd31: v = 64'h142929670a0e6e70;
      7'd32: v = 64'h27b70a8546d22ffc;
      7'd33: v = 64'h2e1b21385c26c926;
      7'd34: v = 64'h4d2c6dfc5ac42aed;
      7'd35: v = 64'h53380d139d95b3df;
      7'd36: v = 64'h650a73548baf63de;
      7'd37: v = 64'h766a0abb3c77b2a8;
      7'd38: v = 64'h81c2c92e47edaee6;
      7'd39: v = 64'h92722c851482353b;
      7'd40: v = 64'ha2bfe8a14cf10364;
      7'd41: v = 64'ha81a664bbc423001;
      7'd42: v = 64'hc24b8b70d0f89791;
      7'd43: v = 64'hc76c51a30654be30;
      7'd44: v = 64'hd192e819d6ef5218;
      7'd45: v = 64'hd69906245565a910;
      7'd46: v = 64'hf40e35855771202a;
      7'd47: v = 64'h106aa07032bbd1b8;
      7'd48: v = 64'h19a4c116b8d2d0c8;
      7'd49: v = 64'h1e376c085141ab53;
      7'd50: v = 64'h2748774cdf8eeb99;
      7'd51: v = 64'h34b0bcb5e19b48a8;
      7'd52: v = 64'h391c0cb3c5c95a63;
      7'd53: v = 64'h4ed8aa4ae3418acb;
      7'd54: v = 64'h5b9cca4f7763e373;
      7'd55: v = 64'h682e6ff3d6b2b8a3;
      7'd56: v = 64'h748f82ee5defb2fc;
      7'd57: v = 64'h78a5636f43172f60;
      7'd58: v = 64'h84c87814a1f0ab72;
      7'd59: v = 64'h8cc702081a6439ec;
      7'd60: v = 64'h90befffa23631e28;
      7'd61: v = 64'ha4506cebde82bde9;
      7'd62: v = 64'hbef9a3f7b2c67915;
      7'd63: v = 64'hc67178f2e372532b;
      7'd64: v = 64'hca273eceea26619c;
      7'd65: v = 64'hd186b8c721c0c207;
      7'd66: v = 64'heada7dd6cde0eb1e;
      7'd67: v = 64'hf57d4f7fee6ed178;
      7'd68: v = 64'h06f067aa72176fba;
      7'd69: v = 64'h0a637dc5a2c898a6;
      7'd70: v = 64'h113f9804bef90dae;
      7'd71: v = 64'h1b710b35131c471b;
      7'd72: v = 64'h28db77f523047d84;
      7'd73: v = 64'h32caab7b40c72493;
      7'd74: v = 64'h3c9ebe0a15c9bebc;
      7'd75: v = 64'h431d67c49c100d4c;
      7'd76: v = 64'h4cc5d4becb3e42b6;
      7'd77: v = 64'h597f299cfc657e2a;
      7'd78: v = 64'h5fcb6fab3ad6faec;
      7'd79: v = 64'h6c44198c4a475817;
      default: v = 64'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/sha512_round.sv =====
module sha512_round import sha512_pkg::*; (
  input  vars_t       vars_in,
  input  logic [63:0] k,
  input  sched_taps_t taps,
  output vars_t       vars_out,
  output logic [63:0] sched_word
);

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] a, b, c, d, e, f, g, h;
  logic [63:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [63:0] small_s0, small_s1;

  assign a = vars_in[0];
  assign b = vars_in[1];
  assign c = vars_in[2];
  assign d = vars_in[3];
  assign e = vars_in[4];
  assign f = vars_in[5];
  assign g = vars_in[6];
  assign h = vars_in[7];

  // Compression round, current schedule word is the oldest tap
  assign big_s1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
  assign big_s0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
  assign ch     = (e & f) ^ (~e & g);
  assign maj    = (a & b) ^ (a & c) ^ (b & c);
  assign t1     = h + big_s1 + ch + k + taps.w0;
  assign t2     = big_s0 + maj;

  always_comb begin
    vars_out[0] = t1 + t2;
    vars_out[1] = a;
    vars_out[2] = b;
    vars_out[3] = c;
    vars_out[4] = d + t1;
    vars_out[5] = e;
    vars_out[6] = f;
    vars_out[7] = g;
  end

  // Schedule expansion: W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
  assign small_s1   = rotr(taps.w14, 19) ^ rotr(taps.w14, 61) ^ (taps.w14 >> 6);
  assign small_s0   = rotr(taps.w1, 1) ^ rotr(taps.w1, 8) ^ (taps.w1 >> 7);
  assign sched_word = small_s1 + taps.w9 + small_s0 + taps.w0;

endmodule

// ===== sv/sha512_compression.sv =====
// SHA-512 compression core. Feed the padded message one 64-bit big-endian
// word per start pulse (accepted when start is high and busy is low), 16 words
// per block; set final_block on the sixteenth word of the last block. The first
// fifteen words of a block are accepted without raising busy. The sixteenth
// word raises busy for 80 rounds through a single round unit, one round per
// cycle, then a step that adds the working variables into the chaining value.
// On a final block busy stays high while the digest is read out. Each word
// appears in the next cycle through the result register, H0 first, one word
// per cycle with strobe high, so the eighth word, marked by last, shows
// after busy has fallen. Results cannot be held off: the receiver must take
// each word in the cycle it appears. After the digest the chaining value
// returns to the standard initial value for the next message.
module sha512_compression import sha512_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  msg_t    msg,
  output logic    busy,
  output logic    strobe,
  output digest_t dig
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state;
  logic [3:0]        word_count;
  logic [6:0]        round_cnt;
  logic [2:0]        out_idx;
  logic              fin;
  vars_t             chain_value;
  vars_t             working_vars;
  logic [15:0][63:0] schedule_window;

  vars_t       round_out;
  logic [63:0] sched_word;
  sched_taps_t taps;
  logic        accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Round unit taps into the schedule shift line
  assign taps.w0  = schedule_window[0];
  assign taps.w1  = schedule_window[1];
  assign taps.w9  = schedule_window[9];
  assign taps.w14 = schedule_window[14];

  sha512_round u_round (
    .vars_in    (working_vars),
    .k          (round_k(round_cnt)),
    .taps       (taps),
    .vars_out   (round_out),
    .sched_word (sched_word)
  );

  // Sequencer and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_count <= 4'd0;
      round_cnt  <= 7'd0;
      out_idx    <= 3'd0;
      fin        <= 1'b0;
      strobe     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_value[i] <= init_hash(3'(i));
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            word_count <= word_count + 4'd1;
            if (word_count == 4'(WORDS_PER_BLOCK - 1)) begin
              state     <= ST_ROUND;
              round_cnt <= 7'd0;
              fin       <= msg.final_block;
            end
          end
        end
        ST_ROUND: begin
          round_cnt <= round_cnt + 7'd1;
          if (round_cnt == 7'(ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain_value[i] <= chain_value[i] + working_vars[i];
          end
          out_idx <= 3'd0;
          state   <= fin ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          strobe  <= 1'b1;
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'(DIGEST_WORDS - 1)) begin
            state <= ST_IDLE;
            for (int i = 0; i < 8; i++) begin
              chain_value[i] <= init_hash(3'(i));
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: schedule line, working variables, result register
  always_ff @(posedge clk) begin
    if (accept) begin
      schedule_window <= {msg.msg_word, schedule_window[15:1]};
    end else if (state == ST_ROUND) begin
      schedule_window <= {sched_word, schedule_window[15:1]};
    end
    if (accept && word_count == 4'(WORDS_PER_BLOCK - 1)) begin
      working_vars <= chain_value;
    end else if (state == ST_ROUND) begin
      working_vars <= round_out;
    end
    if (state == ST_OUT) begin
      dig.digest_word  <= chain_value[out_idx];
      dig.digest_index <= out_idx;
      dig.last         <= (out_idx == 3'(DIGEST_WORDS - 1));
    end
  end

  // Checks
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && dig.last |=> !strobe)
    else $error("strobe continued after last digest word");

  a_burst_starts_at_h0: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> dig.digest_index == 3'd0)
    else $error("digest burst did not start at index 0");

  a_block_end_busy: assert property (@(posedge clk) disable iff (rst)
    accept && word_count == 4'(WORDS_PER_BLOCK - 1) |=> busy)
    else $error("block end did not start compression");

  a_mid_burst_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !dig.last |-> busy)
    else $error("block idle in the middle of a digest burst");

endmodule
